>>> sv/greedy_iou_box_suppressor_top_macros.svh
// assertion macros used by the checker file of the box suppressor
// no dependencies
`ifndef GREEDY_IOU_BOX_SUPPRESSOR_TOP_MACROS_SVH
`define GREEDY_IOU_BOX_SUPPRESSOR_TOP_MACROS_SVH

// property checked outside reset
`define GIS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("box suppressor assertion failed");

// property checked on every edge, reset included
`define GIS_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("box suppressor assertion failed");

`endif

>>> sv/gis_pkg.sv
// types, widths and codes of the greedy overlap box suppressor
// no dependencies
package gis_pkg;

   localparam int MAX_KEPT   = 64;
   localparam int COORD_BITS = 12;

   localparam int POS_W  = COORD_BITS;
   localparam int SIZE_W = COORD_BITS + 1;
   localparam int EDGE_W = SIZE_W + 1;
   localparam int SPAN_W = EDGE_W;
   localparam int AREA_W = 2 * SIZE_W;
   localparam int INNER_W = 2 * SPAN_W;
   localparam int UNI_W  = INNER_W + 1;
   localparam int Q_BITS = 8;

   localparam int CNT_W  = $clog2(MAX_KEPT + 1);
   localparam int ADDR_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

   localparam int THR_W = 9;
   localparam int LIM_W = 13;
   localparam int RHS_W = THR_W + UNI_W - 1;
   localparam int ASP_W = LIM_W + SIZE_W;

   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = LIM_W;

   localparam logic [CSR_ADDR_W-1:0] CSR_OVERLAP_THR  = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ASPECT_LIMIT = 1'd1;

   localparam logic [THR_W-1:0] THR_RESET = 9'd128;
   localparam logic [LIM_W-1:0] LIM_RESET = 13'd8;

   localparam logic [1:0] VERDICT_KEPT    = 2'd0;
   localparam logic [1:0] VERDICT_OVERLAP = 2'd1;
   localparam logic [1:0] VERDICT_ASPECT  = 2'd2;
   localparam logic [1:0] VERDICT_FULL    = 2'd3;

   localparam logic [CNT_W-1:0] MAX_KEPT_C = CNT_W'(MAX_KEPT);

   typedef struct packed {
      logic [POS_W-1:0]  box_left;
      logic [POS_W-1:0]  box_top;
      logic [SIZE_W-1:0] box_width;
      logic [SIZE_W-1:0] box_height;
      logic              starts_set;
   } req_type;

   typedef struct packed {
      logic             accepted;
      logic [1:0]       verdict;
      logic [CNT_W-1:0] accepted_total;
   } rsp_type;

   typedef struct packed {
      logic [POS_W-1:0]  left;
      logic [POS_W-1:0]  top;
      logic [SIZE_W-1:0] width;
      logic [SIZE_W-1:0] height;
   } entry_type;

   typedef struct packed {
      logic clear;
      logic issue;
   } ovl_ctrl_type;

   typedef struct packed {
      logic busy;
      logic hit;
   } ovl_stat_type;

endpackage

>>> sv/greedy_iou_box_suppressor_top.sv
// top level of the greedy overlap box suppressor: sequencer, box store, registers
// depends on gis_pkg, gis_ram, gis_overlap
//
//   channel | ports                              | direction
//   req     | req_valid, req_ready, req_data     | in, one candidate box per request
//   rsp     | rsp_valid, rsp_ready, rsp_data     | out, one verdict per request
//   csr     | csr_we, csr_addr, csr_wdata        | in, register writes
//
// the first box of a set skips the store scan; a later box is tested against the
// kept boxes, read one per cycle from the store through a registered read and a
// four-stage overlap pipeline
// reset is synchronous; the store needs no clearing, only the count is reset
// a request is taken while an earlier verdict waits in the output register;
// the verdict after it waits for rsp_ready before the store is updated
module greedy_iou_box_suppressor_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  gis_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output gis_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [gis_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [gis_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import gis_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_DRAIN  = 2'd2;
   localparam logic [1:0] S_DECIDE = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   entry_type        box_ff;
   logic             first_ff;
   logic [THR_W-1:0] thr_ff;
   logic [LIM_W-1:0] lim_ff;
   logic [ASP_W-1:0] lim_h_ff, lim_w_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             accept, commit, aspect_bad;
   logic [CNT_W-1:0] eff_count;
   logic [1:0]       verdict_c;
   ovl_ctrl_type     ovl_ctrl;
   ovl_stat_type     ovl_stat;
   entry_type        rd_data;
   entry_type        req_box;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign commit    = (state_ff == S_DECIDE) && (!rsp_valid_ff || rsp_ready);

   assign req_box.left   = req_data.box_left;
   assign req_box.top    = req_data.box_top;
   assign req_box.width  = req_data.box_width;
   assign req_box.height = req_data.box_height;

   assign ovl_ctrl.clear = accept;
   assign ovl_ctrl.issue = (state_ff == S_SCAN) && (idx_ff != count_ff);

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
         lim_ff <= LIM_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_OVERLAP_THR:  thr_ff <= csr_wdata[THR_W-1:0];
            CSR_ASPECT_LIMIT: lim_ff <= csr_wdata[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   // aspect products
   always_ff @(posedge clock) begin
      lim_h_ff <= ASP_W'(lim_ff) * ASP_W'(box_ff.height);
      lim_w_ff <= ASP_W'(lim_ff) * ASP_W'(box_ff.width);
   end

   assign aspect_bad = ({{(ASP_W-SIZE_W){1'b0}}, box_ff.width} >= lim_h_ff)
                    || ({{(ASP_W-SIZE_W){1'b0}}, box_ff.height} >= lim_w_ff);

   assign eff_count = first_ff ? '0 : count_ff;

   always_comb begin
      if (first_ff) begin
         verdict_c = VERDICT_KEPT;
      end else if (ovl_stat.hit) begin
         verdict_c = VERDICT_OVERLAP;
      end else if (aspect_bad) begin
         verdict_c = VERDICT_ASPECT;
      end else begin
         verdict_c = VERDICT_KEPT;
      end
      if ((verdict_c == VERDICT_KEPT) && (eff_count >= MAX_KEPT_C)) begin
         verdict_c = VERDICT_FULL;
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            if (accept) begin
               state_in = req_data.starts_set ? S_DECIDE : S_SCAN;
            end
         end
         S_SCAN: begin
            if (idx_ff == count_ff) begin
               state_in = S_DRAIN;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         S_DRAIN: begin
            if (!ovl_stat.busy) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (commit) begin
               count_in = (verdict_c == VERDICT_KEPT) ? eff_count + CNT_W'(1) : eff_count;
               rsp_valid_in          = 1'b1;
               rsp_in.accepted       = (verdict_c == VERDICT_KEPT);
               rsp_in.verdict        = verdict_c;
               rsp_in.accepted_total = count_in;
               state_in              = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (accept) begin
         box_ff   <= req_box;
         first_ff <= req_data.starts_set;
      end
   end

   gis_ram #(
      .WIDTH  ($bits(entry_type)),
      .DEPTH  (MAX_KEPT),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (commit && (verdict_c == VERDICT_KEPT)),
      .wr_addr (eff_count[ADDR_W-1:0]),
      .wr_data (box_ff),
      .rd_en   (ovl_ctrl.issue),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   gis_overlap u_overlap (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ovl_ctrl),
      .box     (box_ff),
      .thr     (thr_ff),
      .rd_data (rd_data),
      .stat    (ovl_stat)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> sv/gis_ram.sv
// generic single-clock ram, one write port and one registered read port
// no dependencies
module gis_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/gis_overlap.sv
// pipelined overlap test of the candidate box against one stored box per cycle
// depends on gis_pkg
module gis_overlap (
   input  logic                     clock,
   input  logic                     reset,
   input  gis_pkg::ovl_ctrl_type    ctrl,
   input  gis_pkg::entry_type       box,
   input  logic [gis_pkg::THR_W-1:0] thr,
   input  gis_pkg::entry_type       rd_data,
   output gis_pkg::ovl_stat_type    stat
);

   import gis_pkg::*;

   function automatic logic [SPAN_W-1:0] span_len(
      input logic [POS_W-1:0]  a0,
      input logic [SIZE_W-1:0] aw,
      input logic [POS_W-1:0]  b0,
      input logic [SIZE_W-1:0] bw
   );
      logic [EDGE_W-1:0] a_lo, b_lo, a_hi, b_hi, lo, hi;
      logic [EDGE_W:0]   diff;
      a_lo = {{(EDGE_W-POS_W){1'b0}}, a0};
      b_lo = {{(EDGE_W-POS_W){1'b0}}, b0};
      a_hi = a_lo + {{(EDGE_W-SIZE_W){1'b0}}, aw};
      b_hi = b_lo + {{(EDGE_W-SIZE_W){1'b0}}, bw};
      lo   = (a_lo > b_lo) ? a_lo : b_lo;
      hi   = (a_hi < b_hi) ? a_hi : b_hi;
      diff = {1'b0, hi} + {{EDGE_W{1'b0}}, 1'b1} - {1'b0, lo};
      span_len = (hi >= lo) ? diff[SPAN_W-1:0] : '0;
   endfunction

   logic                      v_rd_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   logic [AREA_W-1:0]         box_area_ff;
   logic [SPAN_W-1:0]         s1_iw_ff, s1_ih_ff;
   logic [SIZE_W-1:0]         s1_sw_ff, s1_sh_ff;
   logic [INNER_W-1:0]        s2_inner_ff;
   logic [AREA_W-1:0]         s2_sarea_ff;
   logic [INNER_W-1:0]        s3_inner_ff;
   logic signed [UNI_W-1:0]   s3_uni_ff;
   logic signed [UNI_W-1:0]   uni_in;
   logic [INNER_W-1:0]        s4_inner_ff;
   logic [RHS_W-1:0]          s4_rhs_ff;
   logic                      s4_pos_ff, s4_zero_ff;
   logic [RHS_W-1:0]          lhs;
   logic                      over;
   logic                      hit_ff;

   // pipe valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v_rd_ff <= 1'b0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         v4_ff   <= 1'b0;
      end else begin
         v_rd_ff <= ctrl.issue;
         v1_ff   <= v_rd_ff;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         v4_ff   <= v3_ff;
      end
   end

   assign uni_in = $signed({{(UNI_W-AREA_W){1'b0}}, box_area_ff})
                 + $signed({{(UNI_W-AREA_W){1'b0}}, s2_sarea_ff})
                 - $signed({1'b0, s2_inner_ff});

   always_ff @(posedge clock) begin
      box_area_ff <= AREA_W'(box.width) * AREA_W'(box.height);
      s1_iw_ff    <= span_len(box.left, box.width, rd_data.left, rd_data.width);
      s1_ih_ff    <= span_len(box.top, box.height, rd_data.top, rd_data.height);
      s1_sw_ff    <= rd_data.width;
      s1_sh_ff    <= rd_data.height;
      s2_inner_ff <= INNER_W'(s1_iw_ff) * INNER_W'(s1_ih_ff);
      s2_sarea_ff <= AREA_W'(s1_sw_ff) * AREA_W'(s1_sh_ff);
      s3_inner_ff <= s2_inner_ff;
      s3_uni_ff   <= uni_in;
      s4_inner_ff <= s3_inner_ff;
      s4_pos_ff   <= !s3_uni_ff[UNI_W-1] && (s3_uni_ff != '0);
      s4_zero_ff  <= (s3_uni_ff == '0);
      s4_rhs_ff   <= {{(RHS_W-THR_W){1'b0}}, thr}
                   * {{(RHS_W-UNI_W+1){1'b0}}, s3_uni_ff[UNI_W-2:0]};
   end

   assign lhs  = {{(RHS_W-INNER_W-Q_BITS){1'b0}}, s4_inner_ff, {Q_BITS{1'b0}}};
   assign over = (s4_pos_ff && (lhs > s4_rhs_ff)) || (s4_zero_ff && (s4_inner_ff != '0));

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         hit_ff <= 1'b0;
      end else if (v4_ff && over) begin
         hit_ff <= 1'b1;
      end
   end

   assign stat.busy = v_rd_ff | v1_ff | v2_ff | v3_ff | v4_ff;
   assign stat.hit  = hit_ff;

endmodule

>>> sv/gis_checker.sv
// port-level checks of the box suppressor, bound to the top level
// depends on gis_pkg and greedy_iou_box_suppressor_top_macros.svh
`include "greedy_iou_box_suppressor_top_macros.svh"

module gis_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input gis_pkg::rsp_type rsp_data
);

   import gis_pkg::*;

   logic rsp_kept, rsp_full, rsp_at_max;

   assign rsp_kept   = (rsp_data.verdict == VERDICT_KEPT);
   assign rsp_full   = (rsp_data.verdict == VERDICT_FULL);
   assign rsp_at_max = (rsp_data.accepted_total == MAX_KEPT_C);

   `GIS_ASSERT_ALWAYS(a_no_rsp_after_reset, clock, reset |=> !rsp_valid)
   `GIS_ASSERT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
   `GIS_ASSERT(a_accept_matches_verdict, clock, reset, rsp_valid |-> (rsp_data.accepted == rsp_kept))
   `GIS_ASSERT(a_total_bounded, clock, reset, rsp_valid |-> (rsp_data.accepted_total <= MAX_KEPT_C))
   `GIS_ASSERT(a_full_at_limit, clock, reset, rsp_valid && rsp_full |-> rsp_at_max)

endmodule

bind greedy_iou_box_suppressor_top gis_checker u_gis_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> tb/sv/gis_verdict_checker.sv
// checker for the greedy overlap box suppressor: keeps its own box store and
// register copies, predicts each verdict and compares it with the rsp channel
// depends on gis_pkg
module gis_verdict_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  gis_pkg::req_type               req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  gis_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [gis_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [gis_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             mismatch_count,
   output int                             pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import gis_pkg::*;

   logic [POS_W-1:0]  kept_left   [MAX_KEPT];
   logic [POS_W-1:0]  kept_top    [MAX_KEPT];
   logic [SIZE_W-1:0] kept_width  [MAX_KEPT];
   logic [SIZE_W-1:0] kept_height [MAX_KEPT];
   int                kept_count;
   logic [THR_W-1:0]  overlap_thr;
   logic [LIM_W-1:0]  aspect_lim;
   rsp_type           verdict_queue [$];

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
      kept_count     = 0;
      overlap_thr    = THR_RESET;
      aspect_lim     = LIM_RESET;
   end

   function automatic longint span_overlap(longint a0, longint a1, longint b0, longint b1);
      longint lo, hi, d;
      lo = (a0 > b0) ? a0 : b0;
      hi = (a1 < b1) ? a1 : b1;
      d  = hi - lo + 1;
      return (d > 0) ? d : 0;
   endfunction

   function automatic bit exceeds_overlap(req_type b, int k);
      longint iw, ih, inner, uni;
      iw = span_overlap(longint'(b.box_left), longint'(b.box_left) + longint'(b.box_width),
                        longint'(kept_left[k]),
                        longint'(kept_left[k]) + longint'(kept_width[k]));
      ih = span_overlap(longint'(b.box_top), longint'(b.box_top) + longint'(b.box_height),
                        longint'(kept_top[k]),
                        longint'(kept_top[k]) + longint'(kept_height[k]));
      inner = iw * ih;
      uni   = longint'(b.box_width) * longint'(b.box_height)
            + longint'(kept_width[k]) * longint'(kept_height[k]) - inner;
      if (uni > 0)
         return inner * 256 > longint'(overlap_thr) * uni;
      return (uni == 0) && (inner > 0);
   endfunction

   function automatic rsp_type predict_box(req_type b);
      rsp_type    r;
      logic [1:0] v;
      longint     lim, w, h;
      v   = VERDICT_KEPT;
      lim = longint'(aspect_lim);
      w   = longint'(b.box_width);
      h   = longint'(b.box_height);
      if (b.starts_set) begin
         kept_count = 0;
      end else begin
         for (int k = 0; k < kept_count; k++) begin
            if (exceeds_overlap(b, k)) begin
               v = VERDICT_OVERLAP;
               break;
            end
         end
         if (v == VERDICT_KEPT && (w >= lim * h || h >= lim * w))
            v = VERDICT_ASPECT;
      end
      if (v == VERDICT_KEPT) begin
         if (kept_count >= MAX_KEPT) begin
            v = VERDICT_FULL;
         end else begin
            kept_left[kept_count]   = b.box_left;
            kept_top[kept_count]    = b.box_top;
            kept_width[kept_count]  = b.box_width;
            kept_height[kept_count] = b.box_height;
            kept_count++;
         end
      end
      r.accepted       = (v == VERDICT_KEPT);
      r.verdict        = v;
      r.accepted_total = CNT_W'(kept_count);
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         kept_count  = 0;
         overlap_thr = THR_RESET;
         aspect_lim  = LIM_RESET;
         verdict_queue.delete();
      end else begin
         if (req_valid && req_ready)
            verdict_queue.insert(verdict_queue.size(), predict_box(req_data));
         if (rsp_valid && rsp_ready) begin
            if (verdict_queue.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: verdict with nothing pending: acc=%0b verdict=%0d total=%0d",
                           $realtime, rsp_data.accepted, rsp_data.verdict,
                           rsp_data.accepted_total);
               mismatch_count++;
            end else begin
               want = verdict_queue.pop_front();
               if (rsp_data.accepted !== want.accepted || rsp_data.verdict !== want.verdict ||
                   rsp_data.accepted_total !== want.accepted_total) begin
                  if (mismatch_count < 10) begin
                     $write("%0t: verdict mismatch: want acc=%0b verdict=%0d total=%0d",
                            $realtime, want.accepted, want.verdict, want.accepted_total);
                     $display(", got acc=%0b verdict=%0d total=%0d",
                              rsp_data.accepted, rsp_data.verdict, rsp_data.accepted_total);
                  end
                  mismatch_count++;
               end
            end
         end
         if (csr_we) begin
            case (csr_addr)
               CSR_OVERLAP_THR: begin
                  overlap_thr = csr_wdata[THR_W-1:0];
               end
               CSR_ASPECT_LIMIT: begin
                  aspect_lim = csr_wdata[LIM_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
      pending_count = verdict_queue.size();
   end

endmodule

>>> tb/sv/tb_top.sv
// testbench top for the greedy overlap box suppressor: clock, reset, box stimulus,
// register phases, random idling on both channels and the final verdict
// depends on gis_pkg, greedy_iou_box_suppressor_top and gis_verdict_checker
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import gis_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_ITEMS    = 165;
   localparam int GRID_PITCH     = 455;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int mismatch_count;
   int pending_count;
   int boxes_sent;
   int send_idle_pct;
   int recv_stall_pct;
   int quiet_cycles;

   greedy_iou_box_suppressor_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   gis_verdict_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("greedy_iou_box_suppressor_top verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type make_box(int l, int t, int w, int h, bit s);
      req_type b;
      b.box_left   = POS_W'(l);
      b.box_top    = POS_W'(t);
      b.box_width  = SIZE_W'(w);
      b.box_height = SIZE_W'(h);
      b.starts_set = s;
      return b;
   endfunction

   function automatic int clamp_pos(int x);
      return (x < 0) ? 0 : ((x > 4095) ? 4095 : x);
   endfunction

   function automatic int pick_edge_size();
      case ($urandom_range(0, 6))
         0: return 0;
         1: return 1;
         2: return 2;
         3: return 4095;
         4: return 4096;
         5: return 8191;
         default: return $urandom_range(0, 8191);
      endcase
   endfunction

   function automatic int pick_edge_pos();
      case ($urandom_range(0, 4))
         0: return 0;
         1: return 1;
         2: return 4094;
         3: return 4095;
         default: return $urandom_range(0, 4095);
      endcase
   endfunction

   task automatic push_box(input req_type b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
      boxes_sent++;
   endtask

   task automatic drain_verdicts();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
   endtask

   // disjoint boxes on a 9 x 9 grid, enough to fill the store
   task automatic grid_set(input int n);
      int start, slot;
      start = $urandom_range(0, 80);
      for (int i = 0; i < n; i++) begin
         slot = (start + i) % 81;
         push_box(make_box((slot % 9) * GRID_PITCH + $urandom_range(0, 50),
                           (slot / 9) * GRID_PITCH + $urandom_range(0, 50),
                           $urandom_range(100, 400), $urandom_range(100, 400), i == 0));
      end
   endtask

   task automatic cluster_set(input int n);
      int cx, cy;
      cx = $urandom_range(0, 4000);
      cy = $urandom_range(0, 4000);
      for (int i = 0; i < n; i++)
         push_box(make_box(clamp_pos(cx + $urandom_range(0, 80) - 40),
                           clamp_pos(cy + $urandom_range(0, 80) - 40),
                           $urandom_range(10, 120), $urandom_range(10, 120), i == 0));
   endtask

   task automatic noise_burst(input int n);
      for (int i = 0; i < n; i++)
         push_box(make_box($urandom_range(0, 4095), $urandom_range(0, 4095),
                           $urandom_range(0, 8191), $urandom_range(0, 8191),
                           $urandom_range(0, 7) == 0));
   endtask

   task automatic edge_burst(input int n);
      for (int i = 0; i < n; i++)
         push_box(make_box(pick_edge_pos(), pick_edge_pos(), pick_edge_size(),
                           pick_edge_size(), $urandom_range(0, 3) == 0));
   endtask

   task automatic configure_phase(input int phase);
      logic [THR_W-1:0] thr;
      logic [LIM_W-1:0] lim;
      case (phase)
         1: begin thr = 9'd0;   lim = 13'd1;    end
         2: begin thr = 9'd256; lim = 13'd4096; end
         3: begin thr = 9'd511; lim = 13'd8191; end
         4: begin thr = 9'd300; lim = 13'd0;    end
         6: begin thr = 9'd64;  lim = 13'd3;    end
         default: begin
            thr = THR_W'($urandom_range(0, 511));
            lim = LIM_W'($urandom_range(1, 16));
         end
      endcase
      // upper bits of the threshold write are don't-care
      write_reg(CSR_OVERLAP_THR, {4'($urandom), thr});
      write_reg(CSR_ASPECT_LIMIT, lim);
   endtask

   initial begin
      int phase_start;
      int pick;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_ready      = 1'b0;
      csr_we         = 1'b0;
      csr_addr       = '0;
      csr_wdata      = '0;
      boxes_sent     = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      quiet_cycles   = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // no set started yet
      push_box(make_box(100, 100, 20, 20, 1'b0));
      push_box(make_box(4095, 4095, 8191, 8191, 1'b1));
      push_box(make_box(4095, 4095, 8191, 8191, 1'b0));
      // zero sizes and ratios at the limit
      push_box(make_box(0, 0, 0, 5, 1'b0));
      push_box(make_box(0, 0, 0, 0, 1'b0));
      push_box(make_box(0, 0, 8, 1, 1'b0));
      push_box(make_box(0, 0, 1, 8, 1'b0));
      push_box(make_box(0, 0, 7, 1, 1'b0));
      push_box(make_box(0, 0, 7, 1, 1'b0));
      push_box(make_box(4095, 0, 1, 1, 1'b0));
      // union of zero with a real overlap
      push_box(make_box(200, 200, 1, 1, 1'b1));
      push_box(make_box(200, 200, 0, 0, 1'b0));
      // negative union never counts as overlap
      push_box(make_box(200, 200, 0, 0, 1'b1));
      push_box(make_box(200, 200, 0, 0, 1'b0));
      push_box(make_box(1000, 1000, 100, 100, 1'b1));
      push_box(make_box(1050, 1000, 100, 100, 1'b0));
      push_box(make_box(1010, 1010, 100, 100, 1'b0));
      push_box(make_box(0, 4095, 8191, 4096, 1'b0));

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase != 0) begin
            drain_verdicts();
            configure_phase(phase);
         end
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
         endcase
         phase_start = boxes_sent;
         if (phase == 0)
            grid_set(72);
         while (boxes_sent - phase_start < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
               grid_set(($urandom_range(0, 14) == 0) ? $urandom_range(64, 75)
                                                     : $urandom_range(1, 20));
            else if (pick < 75)
               cluster_set($urandom_range(1, 20));
            else if (pick < 90)
               noise_burst($urandom_range(1, 8));
            else
               edge_burst($urandom_range(1, 6));
         end
      end

      drain_verdicts();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("greedy_iou_box_suppressor_top verification clean");
      end else begin
         $display("greedy_iou_box_suppressor_top verification failed");
      end
      $finish;
   end

endmodule
